### design/keyed_member_table_core_macros.svh
// assertion macros used by the checker file
`ifndef KEYED_MEMBER_TABLE_CORE_MACROS_SVH
`define KEYED_MEMBER_TABLE_CORE_MACROS_SVH

// check held off while reset is high
`define KMT_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("keyed member table check failed");

// check that also holds during reset
`define KMT_ASSERT_RST(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("keyed member table reset check failed");

`endif

### design/kmt_pkg.sv
// shared types and constants for the keyed member table
package kmt_pkg;

   localparam int KEY_W  = 8 * 8;
   localparam int ADDR_W = 32;
   localparam int POS_W  = 5;
   localparam int CNT_W  = 6;
   localparam int KIND_W = 2;

   localparam logic [ADDR_W-1:0] NO_ADDR = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic shift;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic walk_end;
      logic is_clear;
      logic is_remove;
      logic out_free;
   } status_type;

endpackage

### design/kmt_ctrl.sv
// request sequencer: accept, scan, shift-down and result hand-off
module kmt_ctrl import kmt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.is_clear) begin
               state_in = ST_DONE;
            end else if (status.match) begin
               cmd.scan = 1'b1;
               state_in = status.is_remove ? ST_SHIFT : ST_DONE;
            end else begin
               cmd.scan = 1'b1;
               if (status.walk_end) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.walk_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/kmt_datapath.sv
// table memories, walk pointer, compare stage and result register
module kmt_datapath import kmt_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [KEY_W+ADDR_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,
   output logic [0:0]            rsp_tuser
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW = (CW > CNT_W) ? CW : CNT_W;

   logic [KEY_W-1:0]  key_mem [DEPTH];
   logic [ADDR_W-1:0] addr_mem [DEPTH];

   kind_type          kind_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [ADDR_W-1:0] addr_ff;

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic              rvld_ff, rvld_in;
   logic [CW-1:0]     ridx_ff;
   logic [KEY_W-1:0]  rkey_ff;
   logic [ADDR_W-1:0] raddr_ff;

   logic              hit_ff, hit_in;
   logic [CW-1:0]     hidx_ff;
   logic [ADDR_W-1:0] haddr_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              ok_ff, ok_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              issue;
   logic              match;
   logic              cap_hit;
   logic              wr_en;
   logic [AW-1:0]     wr_idx;
   logic [KEY_W-1:0]  wr_key;
   logic [ADDR_W-1:0] wr_addr;
   logic              ins_ok;
   logic [CW-1:0]     ridx_dec;
   logic [CW-1:0]     pos_sel;
   logic [XW-1:0]     pos_ext;
   logic [XW-1:0]     cnt_ext;

   assign issue    = (cmd.scan || cmd.shift) && (ptr_ff < count_ff);
   assign match    = rvld_ff && (rkey_ff == key_ff);
   assign cap_hit  = cmd.scan && match;
   assign ins_ok   = !hit_ff && (count_ff < CW'(DEPTH));
   assign ridx_dec = ridx_ff - 1'b1;

   assign status.match     = match;
   assign status.walk_end  = !rvld_ff && (ptr_ff >= count_ff);
   assign status.is_clear  = (kind_ff == KIND_CLEAR);
   assign status.is_remove = (kind_ff == KIND_REMOVE);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // walk pointer and compare stage
   always_comb begin
      ptr_in  = ptr_ff;
      rvld_in = issue;
      hit_in  = hit_ff;
      if (cmd.load) begin
         ptr_in  = '0;
         rvld_in = 1'b0;
         hit_in  = 1'b0;
      end else if (cap_hit) begin
         ptr_in = ridx_ff + 1'b1;
         hit_in = 1'b1;
      end else if (issue) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   // single write port: shift-down during remove, append on insert
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = count_ff[AW-1:0];
      wr_key  = key_ff;
      wr_addr = addr_ff;
      if (cmd.shift && rvld_ff) begin
         wr_en   = 1'b1;
         wr_idx  = ridx_dec[AW-1:0];
         wr_key  = rkey_ff;
         wr_addr = raddr_ff;
      end else if (cmd.commit && kind_ff == KIND_INSERT && ins_ok) begin
         wr_en = 1'b1;
      end
   end

   // result and count update
   always_comb begin
      count_in = count_ff;
      ok_in    = 1'b0;
      pos_sel  = '0;
      faddr_in = NO_ADDR;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (ins_ok) begin
               ok_in    = 1'b1;
               pos_sel  = count_ff;
               faddr_in = addr_ff;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (hit_ff) begin
               ok_in    = 1'b1;
               pos_sel  = hidx_ff;
               faddr_in = haddr_ff;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_LOOKUP: begin
            if (hit_ff) begin
               ok_in    = 1'b1;
               pos_sel  = hidx_ff;
               faddr_in = haddr_ff;
            end
         end
         KIND_CLEAR: begin
            if (count_ff != '0) begin
               ok_in    = 1'b1;
               count_in = '0;
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
      pos_ext = XW'(pos_sel);
      cnt_ext = XW'(count_in);
      pos_in  = pos_ext[POS_W-1:0];
      cnt_in  = cnt_ext[CNT_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rvld_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         rvld_ff      <= rvld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_type'(req_tuser);
         key_ff  <= req_tdata[KEY_W-1:0];
         addr_ff <= req_tdata[KEY_W+ADDR_W-1:KEY_W];
      end
      if (issue) begin
         ridx_ff <= ptr_ff;
      end
      if (cap_hit) begin
         hidx_ff  <= ridx_ff;
         haddr_ff <= raddr_ff;
      end
      if (cmd.commit) begin
         ok_ff    <= ok_in;
         pos_ff   <= pos_in;
         faddr_ff <= faddr_in;
         cnt_ff   <= cnt_in;
      end
   end

   // table memories, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_idx]  <= wr_key;
         addr_mem[wr_idx] <= wr_addr;
      end
      if (issue) begin
         rkey_ff  <= key_mem[ptr_ff[AW-1:0]];
         raddr_ff <= addr_mem[ptr_ff[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = {5'd0, cnt_ff, faddr_ff, pos_ff};

endmodule

### design/keyed_member_table_core.sv
// keyed member table: up to DEPTH key/address members, insert, remove, lookup, clear
// a request walks the stored members in order, reading each one and comparing its key
// a hit ends the walk; a remove then shifts the later members down by one place
// clear or any request on an empty table skips the walk; a waiting result holds the commit
// one request in work at a time; the next is accepted only after the result is registered
// reset clears the member count and the controls; stored entries are left as is
module keyed_member_table_core import kmt_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [KEY_W+ADDR_W-1:0] req_tdata,   // member_key, member_addr
   input  logic [KIND_W-1:0]       req_tuser,   // kind
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata,   // position, found_addr, member_count
   output logic [0:0]              rsp_tuser    // ok
);

   cmd_type    cmd;
   status_type status;

   kmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   kmt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### design/kmt_checker.sv
// port-level checks for the keyed member table, bound to the top level
`include "keyed_member_table_core_macros.svh"

module kmt_checker #(
   parameter int DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [95:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   `KMT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `KMT_ASSERT(a_fail_fields, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[4:0] == 5'd0 && rsp_tdata[36:5] == 32'hFFFF_FFFF)
   `KMT_ASSERT(a_count_bound, rsp_tvalid |-> (DEPTH > 63) || (rsp_tdata[42:37] <= 6'(DEPTH)))
   `KMT_ASSERT_RST(a_reset_idle, reset |=> !rsp_tvalid && req_tready)

endmodule

bind keyed_member_table_core kmt_checker #(.DEPTH(DEPTH)) u_kmt_checker (.*);
